>>> sv/lpcr_pkg.sv
// Shared types, constants and the CRC-8 step function for the
// length-prefixed CRC-8 frame receiver. No dependencies.
`default_nettype none

package lpcr_pkg;

  // Status codes returned with every byte
  localparam logic [2:0] ST_MID    = 3'd0;
  localparam logic [2:0] ST_GOOD   = 3'd1;
  localparam logic [2:0] ST_SHORT  = 3'd2;
  localparam logic [2:0] ST_LONG   = 3'd3;
  localparam logic [2:0] ST_BADCHK = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  // Reflected CRC-8, no final xor
  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] CRC_INIT      = 8'h00;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
  localparam logic [7:0] MAX_LEN_RESET = 8'd64;

  // Register addresses on the configuration port
  localparam logic [1:0] ADDR_MAX_FRAME_LEN = 2'd0;

  // One result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last_of_frame;
    logic [2:0] status;
  } result_t;

  // Fold one byte into the CRC, least significant bit first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d  = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/lpcr_cfg.sv
// APB-style configuration register file: holds max_frame_len.
// Depends on lpcr_pkg.
`default_nettype none

module lpcr_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  max_frame_len_o
);

  logic [7:0] max_len_q;
  logic [7:0] max_len_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr == lpcr_pkg::ADDR_MAX_FRAME_LEN);

  // Update the register on a completed write transaction
  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpcr_pkg::MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    if (paddr == lpcr_pkg::ADDR_MAX_FRAME_LEN) begin
      prdata = {24'd0, max_len_q};
    end
  end

  assign max_frame_len_o = max_len_q;

endmodule

`default_nettype wire

>>> sv/lpcr_core.sv
// Frame state (running CRC, byte count, length, halt) and the per-byte
// decision logic. Depends on lpcr_pkg.
`default_nettype none

module lpcr_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [7:0]        max_frame_len_i,
  output lpcr_pkg::result_t      result_o
);

  logic [7:0] crc_q, crc_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] len_q, len_d;
  logic       halt_q, halt_d;

  // Classify the byte and compute the next frame state
  always_comb begin
    crc_d  = crc_q;
    seen_d = seen_q;
    len_d  = len_q;
    halt_d = halt_q;
    result_o.data_byte     = rx_byte_i;
    result_o.byte_index    = 8'd0;
    result_o.last_of_frame = 1'b0;
    result_o.status        = lpcr_pkg::ST_MID;
    if (halt_q) begin
      result_o.status = lpcr_pkg::ST_HALTED;
    end else if (seen_q == 8'd0) begin
      // Length byte
      if (rx_byte_i < lpcr_pkg::MIN_FRAME_LEN) begin
        result_o.status = lpcr_pkg::ST_SHORT;
        halt_d          = 1'b1;
      end else if (rx_byte_i > max_frame_len_i) begin
        result_o.status = lpcr_pkg::ST_LONG;
        halt_d          = 1'b1;
      end else begin
        len_d  = rx_byte_i;
        crc_d  = lpcr_pkg::crc_byte(lpcr_pkg::CRC_INIT, rx_byte_i);
        seen_d = 8'd1;
      end
    end else begin
      result_o.byte_index = seen_q;
      if (({1'b0, seen_q} + 9'd1) == {1'b0, len_q}) begin
        // Check byte
        result_o.last_of_frame = 1'b1;
        if (rx_byte_i == crc_q) begin
          result_o.status = lpcr_pkg::ST_GOOD;
          crc_d  = lpcr_pkg::CRC_INIT;
          seen_d = 8'd0;
          len_d  = 8'd0;
        end else begin
          result_o.status = lpcr_pkg::ST_BADCHK;
          halt_d          = 1'b1;
        end
      end else begin
        crc_d  = lpcr_pkg::crc_byte(crc_q, rx_byte_i);
        seen_d = seen_q + 8'd1;
      end
    end
  end

  // Commit state only when the byte moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= lpcr_pkg::CRC_INIT;
      seen_q <= 8'd0;
      len_q  <= 8'd0;
      halt_q <= 1'b0;
    end else if (advance_i) begin
      crc_q  <= crc_d;
      seen_q <= seen_d;
      len_q  <= len_d;
      halt_q <= halt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/length_prefixed_crc8_frame_receiver_top.sv
// Top level of the length-prefixed CRC-8 frame receiver: input register,
// result register and handshake control. Depends on lpcr_pkg, lpcr_cfg, lpcr_core.
//
// Receives one byte per input transaction and returns one result transaction
// per byte (echoed byte, index in frame, last-of-frame mark, status). The
// block sustains one byte per clock while the result side does not stall. An
// accepted byte waits in the input register, and the result register loads
// it when that register is free or draining. The one-byte-per-clock rate
// is set by the state feedback loop in lpcr_core that updates the
// running CRC and byte count for each byte. A fatal error (bad length or bad
// check) latches a halted state that only reset clears. Write max_frame_len
// only while idle.
`default_nettype none

module length_prefixed_crc8_frame_receiver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  data_byte_o,
  output logic      [7:0]  byte_index_o,
  output logic             last_of_frame_o,
  output logic      [2:0]  status_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  logic              out_valid_d;
  lpcr_pkg::result_t out_q;
  lpcr_pkg::result_t result;
  logic [7:0]        max_frame_len;
  logic              advance;
  logic              in_take;

  lpcr_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_frame_len_o (max_frame_len)
  );

  lpcr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .rx_byte_i       (in_byte_q),
    .max_frame_len_i (max_frame_len),
    .result_o        (result)
  );

  // Move a byte forward when the result register is free or draining
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = out_q.data_byte;
  assign byte_index_o    = out_q.byte_index;
  assign last_of_frame_o = out_q.last_of_frame;
  assign status_o        = out_q.status;

endmodule

`default_nettype wire

>>> test/tb_length_prefixed_crc8_frame_receiver_top.sv
// Self-checking testbench for length_prefixed_crc8_frame_receiver_top.
// Drives well-formed CRC-8 frames under several max_frame_len settings and ends
// each run with one fatal case and halted traffic. Depends on lpcr_pkg.
`default_nettype none

module tb_length_prefixed_crc8_frame_receiver_top;
  import lpcr_pkg::*;

  typedef enum int {FATAL_SHORT, FATAL_LONG, FATAL_BADCHK, FATAL_TINY} fatal_kind_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte_o;
  logic [7:0]  byte_index_o;
  logic        last_of_frame_o;
  logic [2:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_MAX_FRAME_LEN;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  length_prefixed_crc8_frame_receiver_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .data_byte_o(data_byte_o), .byte_index_o(byte_index_o),
    .last_of_frame_o(last_of_frame_o), .status_o(status_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver state mirror
  logic [7:0] max_len_cfg = MAX_LEN_RESET;
  logic [7:0] crc_acc = CRC_INIT;
  logic [7:0] bytes_in_frame = 8'd0;
  logic [7:0] frame_len = 8'd0;
  logic       halted = 1'b0;

  logic [7:0] rx_pending[$];
  result_t    expected_results[$];
  int         mismatches = 0;
  int         items_queued = 0;

  // Reflected CRC-8: xor the byte in, then shift out eight bits
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the mirror by one byte and return the result it should produce
  function automatic result_t predict_rx_result(input logic [7:0] b);
    result_t r;
    r.data_byte     = b;
    r.byte_index    = 8'd0;
    r.last_of_frame = 1'b0;
    r.status        = ST_MID;
    if (halted) begin
      r.status = ST_HALTED;
    end else if (bytes_in_frame == 8'd0) begin
      if (b < MIN_FRAME_LEN) begin
        r.status = ST_SHORT;
        halted   = 1'b1;
      end else if (b > max_len_cfg) begin
        r.status = ST_LONG;
        halted   = 1'b1;
      end else begin
        frame_len      = b;
        crc_acc        = crc8_fold(CRC_INIT, b);
        bytes_in_frame = 8'd1;
      end
    end else begin
      r.byte_index = bytes_in_frame;
      if ({1'b0, bytes_in_frame} + 9'd1 == {1'b0, frame_len}) begin
        r.last_of_frame = 1'b1;
        if (b == crc_acc) begin
          r.status       = ST_GOOD;
          crc_acc        = CRC_INIT;
          bytes_in_frame = 8'd0;
          frame_len      = 8'd0;
        end else begin
          r.status = ST_BADCHK;
          halted   = 1'b1;
        end
      end else begin
        crc_acc        = crc8_fold(crc_acc, b);
        bytes_in_frame = bytes_in_frame + 8'd1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    items_queued++;
  endtask

  // Queue one frame; corrupt flips bits of the check byte
  task automatic queue_frame(input int len, input fill_e fill, input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc8_fold(CRC_INIT, len[7:0]);
    push_byte(len[7:0]);
    for (int i = 1; i < len - 1; i++) begin
      case (fill)
        FILL_ZERO: begin
          b = 8'h00;
        end
        FILL_ONES: begin
          b = 8'hFF;
        end
        default: begin
          b = 8'($urandom_range(0, 255));
        end
      endcase
      crc = crc8_fold(crc, b);
      push_byte(b);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(crc);
  endtask

  // Hold the sender until every queued transaction has come back
  task automatic drain();
    while (rx_pending.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write max_frame_len, then read it back
  task automatic write_max_len(input logic [7:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_FRAME_LEN;
    pwdata  <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    max_len_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[7:0] !== v) begin
      report_mismatch("max_frame_len readback", int'(v), int'(prdata[7:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Fill one setting with mostly short frames, some at the limit
  task automatic run_phase(input logic [7:0] max_len, input bit with_longest);
    int start;
    int len;
    int sel;
    int cap;
    fill_e fill;
    start = items_queued;
    write_max_len(max_len);
    if (with_longest) begin
      queue_frame(max_len, FILL_RANDOM, 1'b0);
    end
    while (items_queued - start < PHASE_ITEMS) begin
      sel = $urandom_range(0, 9);
      cap = (max_len < 16) ? max_len : 16;
      if (sel < 6) begin
        len = $urandom_range(5, cap);
      end else if (sel < 8 && max_len <= 64) begin
        len = max_len;
      end else begin
        len = $urandom_range(5, max_len);
      end
      sel = $urandom_range(0, 9);
      fill = (sel == 0) ? FILL_ZERO : (sel == 1) ? FILL_ONES : FILL_RANDOM;
      queue_frame(len, fill, 1'b0);
      if (items_queued - start > PHASE_ITEMS / 2 && $urandom_range(0, 15) == 0) begin
        drain();
      end
    end
    drain();
  endtask

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        expected_results.push_back(predict_rx_result(rx_byte));
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          rx_byte  <= rx_pending.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction, drive the stall pattern
  int stall_mode = 0;
  int stall_run = 0;
  int stall_tick = 0;
  int idle_cycles = 0;
  result_t exp_r;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, data_byte", -1, int'(data_byte_o));
        end else begin
          exp_r = expected_results.pop_front();
          if (data_byte_o !== exp_r.data_byte) begin
            report_mismatch("data_byte", int'(exp_r.data_byte), int'(data_byte_o));
          end
          if (byte_index_o !== exp_r.byte_index) begin
            report_mismatch("byte_index", int'(exp_r.byte_index), int'(byte_index_o));
          end
          if (last_of_frame_o !== exp_r.last_of_frame) begin
            report_mismatch("last_of_frame", int'(exp_r.last_of_frame),
                            int'(last_of_frame_o));
          end
          if (status_o !== exp_r.status) begin
            report_mismatch("status", int'(exp_r.status), int'(status_o));
          end
        end
      end
      // Pick a new stall mode at random when the current stall run ends
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(16, 96);
      end else begin
        stall_run--;
      end
      stall_tick++;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= (stall_tick % 5 < 2);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) != 0);
        end
      endcase
      // Watchdog on cycles with no transaction on either channel
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("length_prefixed_crc8_frame_receiver_top regression: fail");
        $finish;
      end
    end
  end

  // Stimulus sequence
  fatal_kind_e fatal_kind;
  logic [7:0]  lim;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: shortest frames at the tightest limit, all-zero and all-one payloads
    write_max_len(MIN_FRAME_LEN);
    queue_frame(5, FILL_ZERO, 1'b0);
    queue_frame(5, FILL_ONES, 1'b0);
    queue_frame(5, FILL_RANDOM, 1'b0);
    drain();
    write_max_len(8'd255);
    queue_frame(6, FILL_ONES, 1'b0);
    queue_frame(7, FILL_ZERO, 1'b0);
    drain();

    // Random frames under several limits, the extremes among them
    run_phase(8'd255, 1'b1);
    run_phase(8'($urandom_range(5, 255)), 1'b0);
    run_phase(MIN_FRAME_LEN, 1'b0);
    run_phase(8'($urandom_range(5, 40)), 1'b0);
    run_phase(8'($urandom_range(5, 255)), 1'b0);
    run_phase(MAX_LEN_RESET, 1'b0);

    // End with one fatal case, then traffic while halted
    fatal_kind = fatal_kind_e'($urandom_range(0, 3));
    case (fatal_kind)
      FATAL_SHORT: begin
        queue_frame(8, FILL_RANDOM, 1'b0);
        push_byte(8'($urandom_range(0, 4)));
      end
      FATAL_LONG: begin
        lim = 8'($urandom_range(5, 254));
        write_max_len(lim);
        push_byte(8'($urandom_range(lim + 1, 255)));
      end
      FATAL_BADCHK: begin
        queue_frame(5, FILL_RANDOM, 1'b0);
        queue_frame($urandom_range(5, 20), FILL_RANDOM, 1'b1);
      end
      default: begin
        write_max_len(8'($urandom_range(0, 4)));
        push_byte(8'($urandom_range(0, 255)));
      end
    endcase
    for (int i = 0; i < 48; i++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("length_prefixed_crc8_frame_receiver_top regression: pass");
    end else begin
      $display("length_prefixed_crc8_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
